// ----- hdl/sms_pkg.sv -----
// shared types and codes for the substitution matrix scorer
`default_nettype none
package sms_pkg;

  localparam int LETTER_W = 5;
  localparam int FREQ_W   = 16;
  localparam int SUB_W    = 16;
  localparam int SCORE_W  = 40;
  localparam int ACC_W    = 64;

  typedef enum logic [2:0] {
    KIND_MATRIX  = 3'd0,
    KIND_PROF_A  = 3'd1,
    KIND_PROF_B  = 3'd2,
    KIND_RES_A   = 3'd3,
    KIND_RES_B   = 3'd4,
    KIND_QUERY   = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    REG_MODE  = 2'd0,
    REG_LEN_A = 2'd1,
    REG_LEN_B = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    MODE_SEQ_SEQ   = 2'd0,
    MODE_PROF_SEQ  = 2'd1,
    MODE_PROF_PROF = 2'd2
  } score_mode_t;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_RES   = 5'b00010,
    ST_RUN   = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_FIN   = 5'b10000
  } state_t;

  typedef struct packed {
    logic issue;
    logic clear;
  } mac_ctl_t;

endpackage
`default_nettype wire

// ----- hdl/sms_if.sv -----
// channel interfaces for input words, result words and register writes
`default_nettype none
interface sms_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [9:0]  position;
  logic [4:0]  letter_row;
  logic [4:0]  letter_col;
  logic signed [15:0] matrix_value;
  logic [15:0] freq_value;
  logic [4:0]  residue_code;
  logic [10:0] cell_row;
  logic [10:0] cell_col;
  modport source (output valid, kind, position, letter_row, letter_col, matrix_value,
                  freq_value, residue_code, cell_row, cell_col, input ready);
  modport sink (input valid, kind, position, letter_row, letter_col, matrix_value,
                freq_value, residue_code, cell_row, cell_col, output ready);
endinterface

interface sms_out_if;
  logic        valid;
  logic        ready;
  logic signed [39:0] score;
  logic        range_error;
  modport source (output valid, score, range_error, input ready);
  modport sink (input valid, score, range_error, output ready);
endinterface

interface sms_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  addr;
  logic [10:0] wdata;
  modport source (output valid, addr, wdata, input ready);
  modport sink (input valid, addr, wdata, output ready);
endinterface
`default_nettype wire

// ----- hdl/sms_mac.sv -----
// multiply-accumulate pipeline fed by the registered memory read data
`default_nettype none
module sms_mac (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire sms_pkg::mac_ctl_t          ctl,
  input  wire logic [1:0]                 mode,
  input  wire logic [sms_pkg::FREQ_W-1:0] pa_q,
  input  wire logic [sms_pkg::FREQ_W-1:0] pb_q,
  input  wire logic signed [sms_pkg::SUB_W-1:0] sm_q,
  output logic signed [sms_pkg::ACC_W-1:0] acc,
  output logic                            busy
);
  logic v1_r, v2_r, v3_r;
  logic [2*sms_pkg::FREQ_W-1:0] p_r;
  logic signed [sms_pkg::SUB_W-1:0] s_r;
  logic signed [2*sms_pkg::FREQ_W+sms_pkg::SUB_W:0] prod_r;
  logic signed [sms_pkg::ACC_W-1:0] acc_r;
  logic [sms_pkg::FREQ_W-1:0] f1, f2;

  // unused factors become one so all modes share the same pipe
  assign f1 = (mode == sms_pkg::MODE_SEQ_SEQ) ? sms_pkg::FREQ_W'(1) : pa_q;
  assign f2 = (mode == sms_pkg::MODE_PROF_PROF) ? pb_q : sms_pkg::FREQ_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= ctl.issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    p_r    <= f1 * f2;
    s_r    <= sm_q;
    prod_r <= $signed({1'b0, p_r}) * s_r;
    if (ctl.clear) begin
      acc_r <= '0;
    end else if (v3_r) begin
      acc_r <= acc_r + sms_pkg::ACC_W'(prod_r);
    end
  end

  assign acc  = acc_r;
  assign busy = v1_r | v2_r | v3_r;
endmodule
`default_nettype wire

// ----- hdl/substitution_matrix_scorer_unit.sv -----
// top level of the substitution matrix scorer
// Writes of the matrix, profiles and residues go straight into memory. A query on
// a border or outside cell goes straight to the result stage; an interior query
// takes one product in sequence-sequence mode, ALPHABET products in
// profile-sequence mode and ALPHABET*ALPHABET products in profile-profile
// mode. The time is set by the single multiply-accumulate pipeline, one
// product per cycle, fed by one read port on each memory: a residue read,
// one issue per product, then three pipeline stages and the drain check.
// The next word can be taken in the cycle after the result is loaded. One
// item is worked on at a time; a finished result waits in the output register
// while the next word is taken, and a query that ends while that register is
// still full holds until the receiver takes it.
`default_nettype none
module substitution_matrix_scorer_unit #(
  parameter int ALPHABET = 20,
  parameter int MAX_LEN  = 1024
) (
  input  wire logic clk,
  input  wire logic rst_n,
  sms_in_if.sink    in_ch,
  sms_out_if.source out_ch,
  sms_cfg_if.sink   cfg_ch
);
  localparam int AW  = $clog2(ALPHABET);
  localparam int LW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int SAW = $clog2(ALPHABET * ALPHABET);
  localparam int PAW = $clog2(MAX_LEN * ALPHABET);
  localparam int CW  = 18;
  localparam int SUB_DEPTH  = ALPHABET * ALPHABET;
  localparam int PROF_DEPTH = MAX_LEN * ALPHABET;

  logic signed [sms_pkg::SUB_W-1:0]  sub_mem [SUB_DEPTH];
  logic [sms_pkg::FREQ_W-1:0]        prof_a_mem [PROF_DEPTH];
  logic [sms_pkg::FREQ_W-1:0]        prof_b_mem [PROF_DEPTH];
  logic [sms_pkg::LETTER_W-1:0]      res_a_mem [MAX_LEN];
  logic [sms_pkg::LETTER_W-1:0]      res_b_mem [MAX_LEN];

  sms_pkg::state_t state_r, state_nxt;
  logic [1:0]  mode_r;
  logic [10:0] len_a_r, len_b_r;
  logic [LW-1:0] pa_r, pb_r;
  logic [AW-1:0] k_r, m_r;
  logic zero_r, err_r;
  logic out_valid_r;
  logic signed [sms_pkg::SCORE_W-1:0] out_score_r;
  logic out_err_r;

  logic signed [sms_pkg::SUB_W-1:0] sm_q;
  logic [sms_pkg::FREQ_W-1:0] pa_q, pb_q;
  logic [sms_pkg::LETTER_W-1:0] ra_q, rb_q;

  logic in_fire, is_query, last_step;
  logic [CW-1:0] la, lb, row_x, col_x;
  logic q_err, q_zero;
  logic [sms_pkg::LETTER_W-1:0] srow, scol;
  logic [SAW-1:0] sm_raddr, sm_waddr;
  logic [PAW-1:0] pa_raddr, pb_raddr, p_waddr;
  logic lr_ok, lc_ok, code_ok, pos_ok;
  logic signed [sms_pkg::ACC_W-1:0] acc, scaled;
  logic signed [sms_pkg::SCORE_W-1:0] sat;
  logic mac_busy;
  sms_pkg::mac_ctl_t mac_ctl;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= '0;
      len_a_r <= '0;
      len_b_r <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.addr)
        sms_pkg::REG_MODE:  mode_r  <= cfg_ch.wdata[1:0];
        sms_pkg::REG_LEN_A: len_a_r <= cfg_ch.wdata;
        sms_pkg::REG_LEN_B: len_b_r <= cfg_ch.wdata;
        default: ;
      endcase
    end
  end

  assign in_ch.ready = (state_r == sms_pkg::ST_IDLE);
  assign in_fire  = in_ch.valid & in_ch.ready;
  assign is_query = (in_ch.kind == sms_pkg::KIND_QUERY);

  // write decode
  assign lr_ok   = {1'b0, in_ch.letter_row} < 6'(ALPHABET);
  assign lc_ok   = {1'b0, in_ch.letter_col} < 6'(ALPHABET);
  assign code_ok = {1'b0, in_ch.residue_code} < 6'(ALPHABET);
  assign pos_ok  = CW'(in_ch.position) < CW'(MAX_LEN);
  assign sm_waddr = SAW'(in_ch.letter_row) * SAW'(ALPHABET) + SAW'(in_ch.letter_col);
  assign p_waddr  = PAW'(LW'(in_ch.position)) * PAW'(ALPHABET) + PAW'(in_ch.letter_row);

  // query decode against clamped lengths
  assign la    = (CW'(len_a_r) > CW'(MAX_LEN)) ? CW'(MAX_LEN) : CW'(len_a_r);
  assign lb    = (CW'(len_b_r) > CW'(MAX_LEN)) ? CW'(MAX_LEN) : CW'(len_b_r);
  assign row_x = CW'(in_ch.cell_row);
  assign col_x = CW'(in_ch.cell_col);
  assign q_err  = (row_x > la + CW'(1)) || (col_x > lb + CW'(1));
  assign q_zero = q_err || (row_x == '0) || (col_x == '0) || (row_x > la) ||
                  (col_x > lb) || (mode_r == 2'd3);

  // memory read addresses
  always_comb begin
    case (mode_r)
      sms_pkg::MODE_SEQ_SEQ: begin
        srow = ra_q;
        scol = rb_q;
      end
      sms_pkg::MODE_PROF_SEQ: begin
        srow = rb_q;
        scol = sms_pkg::LETTER_W'(k_r);
      end
      default: begin
        srow = sms_pkg::LETTER_W'(k_r);
        scol = sms_pkg::LETTER_W'(m_r);
      end
    endcase
  end
  assign sm_raddr = SAW'(srow) * SAW'(ALPHABET) + SAW'(scol);
  assign pa_raddr = PAW'(pa_r) * PAW'(ALPHABET) + PAW'(k_r);
  assign pb_raddr = PAW'(pb_r) * PAW'(ALPHABET) + PAW'(m_r);

  always_ff @(posedge clk) begin
    if (in_fire && in_ch.kind == sms_pkg::KIND_MATRIX && lr_ok && lc_ok) begin
      sub_mem[sm_waddr] <= in_ch.matrix_value;
    end
    sm_q <= sub_mem[sm_raddr];
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_ch.kind == sms_pkg::KIND_PROF_A && lr_ok && pos_ok) begin
      prof_a_mem[p_waddr] <= in_ch.freq_value;
    end
    pa_q <= prof_a_mem[pa_raddr];
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_ch.kind == sms_pkg::KIND_PROF_B && lr_ok && pos_ok) begin
      prof_b_mem[p_waddr] <= in_ch.freq_value;
    end
    pb_q <= prof_b_mem[pb_raddr];
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_ch.kind == sms_pkg::KIND_RES_A && code_ok && pos_ok) begin
      res_a_mem[LW'(in_ch.position)] <= in_ch.residue_code;
    end
    ra_q <= res_a_mem[pa_r];
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_ch.kind == sms_pkg::KIND_RES_B && code_ok && pos_ok) begin
      res_b_mem[LW'(in_ch.position)] <= in_ch.residue_code;
    end
    rb_q <= res_b_mem[pb_r];
  end

  always_comb begin
    case (mode_r)
      sms_pkg::MODE_SEQ_SEQ:  last_step = 1'b1;
      sms_pkg::MODE_PROF_SEQ: last_step = (k_r == AW'(ALPHABET - 1));
      default: last_step = (k_r == AW'(ALPHABET - 1)) && (m_r == AW'(ALPHABET - 1));
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sms_pkg::ST_IDLE: begin
        if (in_fire && is_query) begin
          state_nxt = q_zero ? sms_pkg::ST_FIN : sms_pkg::ST_RES;
        end
      end
      sms_pkg::ST_RES: state_nxt = sms_pkg::ST_RUN;
      sms_pkg::ST_RUN: begin
        if (last_step) begin
          state_nxt = sms_pkg::ST_DRAIN;
        end
      end
      sms_pkg::ST_DRAIN: begin
        if (!mac_busy) begin
          state_nxt = sms_pkg::ST_FIN;
        end
      end
      sms_pkg::ST_FIN: begin
        if (!out_valid_r || out_ch.ready) begin
          state_nxt = sms_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sms_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sms_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && is_query) begin
      pa_r   <= LW'(in_ch.cell_row - 11'd1);
      pb_r   <= LW'(in_ch.cell_col - 11'd1);
      zero_r <= q_zero;
      err_r  <= q_err;
      k_r    <= '0;
      m_r    <= '0;
    end else if (state_r == sms_pkg::ST_RUN) begin
      if (mode_r == sms_pkg::MODE_PROF_PROF) begin
        if (m_r == AW'(ALPHABET - 1)) begin
          m_r <= '0;
          k_r <= k_r + AW'(1);
        end else begin
          m_r <= m_r + AW'(1);
        end
      end else begin
        k_r <= k_r + AW'(1);
      end
    end
  end

  assign mac_ctl.issue = (state_r == sms_pkg::ST_RUN);
  assign mac_ctl.clear = in_fire & is_query;

  sms_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .mode  (mode_r),
    .pa_q  (pa_q),
    .pb_q  (pb_q),
    .sm_q  (sm_q),
    .acc   (acc),
    .busy  (mac_busy)
  );

  // back to 16 fraction bits, floor on the right shifts
  always_comb begin
    case (mode_r)
      sms_pkg::MODE_SEQ_SEQ:  scaled = acc <<< 8;
      sms_pkg::MODE_PROF_SEQ: scaled = acc >>> 7;
      default:                scaled = acc >>> 22;
    endcase
    if (scaled > sms_pkg::ACC_W'(64'sd549755813887)) begin
      sat = {1'b0, {(sms_pkg::SCORE_W-1){1'b1}}};
    end else if (scaled < -sms_pkg::ACC_W'(64'sd549755813888)) begin
      sat = {1'b1, {(sms_pkg::SCORE_W-1){1'b0}}};
    end else begin
      sat = sms_pkg::SCORE_W'(scaled);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == sms_pkg::ST_FIN && (!out_valid_r || out_ch.ready)) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == sms_pkg::ST_FIN && (!out_valid_r || out_ch.ready)) begin
      out_score_r <= zero_r ? '0 : sat;
      out_err_r   <= err_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.score       = out_score_r;
  assign out_ch.range_error = out_err_r;
endmodule
`default_nettype wire

// ----- hdl/sms_checker.sv -----
// port-level checks for the scorer and their bind
`default_nettype none
module sms_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic [2:0] in_kind,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [39:0] out_score,
  input wire logic out_range_error
);
  logic in_fire;
  assign in_fire = in_valid & in_ready;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_score))
    else $error("result word dropped or changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_range_error |-> out_score == 40'd0)
    else $error("range error with nonzero score");

  a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_kind != sms_pkg::KIND_QUERY && !out_valid |=> !out_valid)
    else $error("result appeared after a write word");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_kind == sms_pkg::KIND_QUERY |=> !in_ready)
    else $error("input taken while a query is in progress");
endmodule

bind substitution_matrix_scorer_unit sms_checker u_sms_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .in_kind         (in_ch.kind),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_score       (out_ch.score),
  .out_range_error (out_ch.range_error)
);
`default_nettype wire
